// ===== sv/abtt_pkg.sv =====
// Shared types and constants for the array binary tree traversal block.
// Used by every module of the block; depends on nothing.
package abtt_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_PRE    = 2'd1,
    REQ_IN     = 2'd2,
    REQ_POST   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_PRE,
    OP_IN,
    OP_POST
  } op_t;

  typedef enum logic [1:0] {
    PH_DOWN,
    PH_LEFT_DONE,
    PH_RIGHT_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] node_value;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

endpackage

// ===== sv/abtt_front.sv =====
// Front end: accepts request transactions, decodes them into commands and
// queues them for the back end. Depends on abtt_pkg.
module abtt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  abtt_pkg::in_item_t in_item,
  output logic              cmd_vld,
  input  logic              cmd_pop,
  output abtt_pkg::cmd_t    cmd
);

  abtt_pkg::cmd_t slot_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;
  abtt_pkg::cmd_t dec;
  logic           do_push;
  logic           do_pop;

  always_comb begin
    dec.value = in_item.value;
    unique case (abtt_pkg::req_t'(in_item.req_type))
      abtt_pkg::REQ_INSERT: dec.op = abtt_pkg::OP_INSERT;
      abtt_pkg::REQ_PRE:    dec.op = abtt_pkg::OP_PRE;
      abtt_pkg::REQ_IN:     dec.op = abtt_pkg::OP_IN;
      abtt_pkg::REQ_POST:   dec.op = abtt_pkg::OP_POST;
      default:              dec.op = abtt_pkg::OP_INSERT;
    endcase
  end

  assign full    = (cnt_r == 2'd2);
  assign cmd_vld = (cnt_r != 2'd0);
  assign cmd     = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = cmd_pop && cmd_vld;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== sv/abtt_res_q.sv =====
// Result queue: two-entry queue that holds walk results for the receiver.
// Depends on abtt_pkg.
module abtt_res_q (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_push,
  output logic                res_rdy,
  input  abtt_pkg::out_item_t res_item,
  output logic                empty,
  input  logic                pop,
  output abtt_pkg::out_item_t out_item
);

  abtt_pkg::out_item_t slot_r [2];
  logic                wr_ptr_r;
  logic                rd_ptr_r;
  logic [1:0]          cnt_r;
  logic                do_push;
  logic                do_pop;

  assign res_rdy  = (cnt_r != 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign out_item = slot_r[rd_ptr_r];
  assign do_push  = res_push && res_rdy;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= res_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== sv/abtt_back.sv =====
// Back end: node store, insert handling and the stackless tree walker.
// Depends on abtt_pkg.
module abtt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_vld,
  output logic                cmd_pop,
  input  abtt_pkg::cmd_t      cmd,
  output logic                res_push,
  input  logic                res_rdy,
  output abtt_pkg::out_item_t res_item
);

  localparam int CNT_W  = abtt_pkg::CNT_W;
  localparam int ADDR_W = abtt_pkg::ADDR_W;

  logic signed [abtt_pkg::DATA_W-1:0] store [abtt_pkg::CAPACITY];
  logic signed [abtt_pkg::DATA_W-1:0] rd_q_r;

  abtt_pkg::state_t state_r, state_nxt;
  abtt_pkg::phase_t phase_r, phase_nxt;
  abtt_pkg::op_t    op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] cur_r, cur_nxt;
  logic             hold_r, hold_nxt;

  logic             wr_en;
  logic             rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  cur_m1;
  logic [CNT_W:0]    left_slot;
  logic [CNT_W:0]    right_slot;
  logic [CNT_W:0]    cnt_ext;
  logic              visit;
  logic              stall;

  assign left_slot  = {cur_r, 1'b0};
  assign right_slot = {cur_r, 1'b1};
  assign cnt_ext    = {1'b0, cnt_r};
  assign cur_m1     = cur_r - CNT_W'(1);
  assign rd_addr    = cur_m1[ADDR_W-1:0];

  always_comb begin
    priority case (phase_r)
      abtt_pkg::PH_DOWN:      visit = (op_r == abtt_pkg::OP_PRE);
      abtt_pkg::PH_LEFT_DONE: visit = (op_r == abtt_pkg::OP_IN);
      default:                visit = (op_r == abtt_pkg::OP_POST);
    endcase
  end

  assign stall = visit && hold_r && !res_rdy;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    cur_nxt   = cur_r;
    hold_nxt  = hold_r;
    cmd_pop   = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    res_push  = 1'b0;
    res_item.node_value = rd_q_r;
    res_item.last       = 1'b0;
    unique case (state_r)
      abtt_pkg::ST_IDLE: begin
        if (cmd_vld) begin
          cmd_pop = 1'b1;
          if (cmd.op == abtt_pkg::OP_INSERT) begin
            if (cnt_r < CNT_W'(abtt_pkg::CAPACITY)) begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end else if (cnt_r != '0) begin
            op_nxt    = cmd.op;
            cur_nxt   = CNT_W'(1);
            phase_nxt = abtt_pkg::PH_DOWN;
            state_nxt = abtt_pkg::ST_WALK;
          end
        end
      end
      abtt_pkg::ST_WALK: begin
        if (!stall) begin
          res_push = visit && hold_r;
          rd_en    = visit;
          if (visit) begin
            hold_nxt = 1'b1;
          end
          priority case (phase_r)
            abtt_pkg::PH_DOWN: begin
              if (left_slot <= cnt_ext) begin
                cur_nxt = left_slot[CNT_W-1:0];
              end else begin
                phase_nxt = abtt_pkg::PH_LEFT_DONE;
              end
            end
            abtt_pkg::PH_LEFT_DONE: begin
              if (right_slot <= cnt_ext) begin
                cur_nxt   = right_slot[CNT_W-1:0];
                phase_nxt = abtt_pkg::PH_DOWN;
              end else begin
                phase_nxt = abtt_pkg::PH_RIGHT_DONE;
              end
            end
            default: begin
              phase_nxt = cur_r[0] ? abtt_pkg::PH_RIGHT_DONE : abtt_pkg::PH_LEFT_DONE;
              cur_nxt   = cur_r >> 1;
            end
          endcase
          if (cur_nxt == '0) begin
            state_nxt = abtt_pkg::ST_FLUSH;
          end
        end
      end
      abtt_pkg::ST_FLUSH: begin
        if (!hold_r) begin
          state_nxt = abtt_pkg::ST_IDLE;
          phase_nxt = abtt_pkg::PH_DOWN;
        end else if (res_rdy) begin
          res_push      = 1'b1;
          res_item.last = 1'b1;
          hold_nxt      = 1'b0;
          state_nxt     = abtt_pkg::ST_IDLE;
          phase_nxt     = abtt_pkg::PH_DOWN;
        end
      end
      default: begin
        state_nxt = abtt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[cnt_r[ADDR_W-1:0]] <= cmd.value;
    end
    if (rd_en) begin
      rd_q_r <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= abtt_pkg::ST_IDLE;
      phase_r <= abtt_pkg::PH_DOWN;
      op_r    <= abtt_pkg::OP_INSERT;
      cnt_r   <= '0;
      cur_r   <= '0;
      hold_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      cnt_r   <= cnt_nxt;
      cur_r   <= cur_nxt;
      hold_r  <= hold_nxt;
    end
  end

endmodule

// ===== sv/array_binary_tree_traversal_top.sv =====
// Array binary tree traversal block, top level: front end, back end, result queue.
// Depends on abtt_pkg, abtt_front, abtt_back and abtt_res_q.
//
// Request channel: queue style, a transaction is taken when push is high and
// full is low. req_type insert appends value at the next slot (dropped when
// the store already holds CAPACITY nodes); preorder, inorder and postorder
// walk the stored tree. Requests are queued two deep and run in order.
// Result channel: queue style, the oldest result sits on out_item while empty
// is low and leaves when pop is high. A walk of n nodes gives n results, the
// last one flagged; a walk of an empty tree gives none.
// Order of work: an insert is written to the store as the back end takes it; a walk
// starts when the back end picks up the request, passes each node going down, after
// its left and after its right subtree, and ends by flushing the last result; then
// the next request starts. Each result is held by the walker and pushed at its next
// visit. Preorder visits nodes going down; other walks descend first.
// When the receiver stalls, the two-entry result queue fills and the walker
// holds on its next visit; requests keep queuing until full rises.
// Reset (rst_n low, synchronous) empties both queues, clears the node count
// and parks the walker; store contents are not cleared.
module array_binary_tree_traversal_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  abtt_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output abtt_pkg::out_item_t out_item
);

  logic                cmd_vld;
  logic                cmd_pop;
  abtt_pkg::cmd_t      cmd;
  logic                res_push;
  logic                res_rdy;
  abtt_pkg::out_item_t res_item;

  abtt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .cmd_vld (cmd_vld),
    .cmd_pop (cmd_pop),
    .cmd     (cmd)
  );

  abtt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_vld  (cmd_vld),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .res_push (res_push),
    .res_rdy  (res_rdy),
    .res_item (res_item)
  );

  abtt_res_q u_res_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_rdy  (res_rdy),
    .res_item (res_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule
